### hdl/cbcs_pkg.sv
// ============================================================================
// cbcs_pkg: shared constants and types for the cubic Bezier curve sampler
// Holds the register map, the fixed-point widths of the parameter and weight
// datapath, the divider stage split, and the per-stage control struct.
// ============================================================================
package cbcs_pkg;

    // Configuration register map.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int COUNT_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CP0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CP1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CP2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CP3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COUNT = 3'd4;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 16'd1;

    // Curve geometry.
    localparam int NUM_POINTS = 4;
    localparam int NUM_AXES   = 3;

    // Curve parameter u in unsigned Q0.16 and its derived widths.
    localparam int FRAC_BITS = 16;
    localparam int S_W       = FRAC_BITS + 1;      // s = 1 - u, up to 1.0
    localparam int S2_W      = 2 * FRAC_BITS + 1;  // s^2, up to 2^32
    localparam int T2_W      = 2 * FRAC_BITS;      // u^2
    localparam int X3_W      = FRAC_BITS + 2;      // 3s and 3u
    localparam int WEIGHT_FRAC = 3 * FRAC_BITS;    // weights are Q0.48
    localparam int WEIGHT_W  = WEIGHT_FRAC + 1;    // a weight may equal 1.0
    localparam int WT_LO_W   = 24;                 // low slice of a weight
    localparam int WT_HI_W   = WEIGHT_W - WT_LO_W; // high slice of a weight

    // Restoring divider: quotient bits resolved in each pipeline stage.
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES          = FRAC_BITS / DIV_STEPS_PER_STAGE;

    // Parameter defaults for the top level.
    localparam int DEF_COORD_WIDTH = 16;
    localparam int DEF_INDEX_WIDTH = 16;

    // Control that travels alongside the data through every stage.
    typedef struct packed {
        logic vld;
        logic err;
    } t_ctrl;

endpackage

### hdl/cubic_bezier_curve_sampler.sv
// ============================================================================
// cubic_bezier_curve_sampler: pipelined 3-D cubic Bezier curve evaluator
// Divides the sample index by the sample count to get u in Q0.16, forms the
// four Bernstein weights in Q0.48 and returns the rounded weighted sum of the
// control points in signed Q8.8, one point per accepted index.
// ============================================================================
//
//  Channel   Direction  Handshake                 Payload
//  --------  ---------  ------------------------  ---------------------------------
//  config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//  sample    in         start high, busy low      i_sample_index
//  point     out        o_valid, one-cycle strobe o_point_x/y/z, o_index_error
//
//  A new sample index is taken in every clock cycle; busy is only high while
//  reset is asserted. A transfer accepted at a clock edge passes the entry
//  register, eight divider stages of two quotient bits each, then four
//  multiply and sum stages and the output register before it reaches the
//  output ports. The depth is set by the sixteen dependent
//  compare-and-subtract steps of the restoring divider.
//  Reset clears the valid bits of every stage and loads the control points
//  with zero and the sample count with one. The receiver cannot stall, so
//  the pipeline never holds and results leave in the order indices arrived.
//
module cubic_bezier_curve_sampler
    import cbcs_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int INDEX_WIDTH = DEF_INDEX_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,

    input  logic                          start,
    output logic                          busy,
    input  logic [INDEX_WIDTH-1:0]        i_sample_index,

    output logic                          o_valid,
    output logic signed [COORD_WIDTH-1:0] o_point_x,
    output logic signed [COORD_WIDTH-1:0] o_point_y,
    output logic signed [COORD_WIDTH-1:0] o_point_z,
    output logic                          o_index_error
);

    // ------------------------------------------------------------------------
    // Derived widths and stage numbering.
    // ------------------------------------------------------------------------
    localparam int EXT_W = (INDEX_WIDTH > COUNT_W) ? INDEX_WIDTH : COUNT_W;
    localparam int PAD_W = (NUM_AXES * COORD_WIDTH > CFG_DATA_W) ?
                           NUM_AXES * COORD_WIDTH : CFG_DATA_W;
    localparam int PH_W  = COORD_WIDTH + WT_HI_W + 1;  // coord x high slice
    localparam int PL_W  = COORD_WIDTH + WT_LO_W + 1;  // coord x low slice
    localparam int HS_W  = PH_W + 2;                   // sum of four
    localparam int LS_W  = PL_W + 2;
    localparam int TOT_W = COORD_WIDTH + WEIGHT_FRAC + 4;
    localparam int RES_W = TOT_W - WEIGHT_FRAC;
    localparam int WSUM_W = WEIGHT_W + 2;

    localparam int ST_M1      = DIV_STAGES + 1;  // s^2, u^2, 3s, 3u
    localparam int ST_M2      = DIV_STAGES + 2;  // Bernstein weights
    localparam int ST_M3      = DIV_STAGES + 3;  // coordinate products
    localparam int ST_M4      = DIV_STAGES + 4;  // partial sums
    localparam int NUM_STAGES = DIV_STAGES + 5;
    localparam int LATENCY    = NUM_STAGES + 1;

    localparam logic [S_W-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [TOT_W-1:0] ROUND_HALF =
        $signed({{(TOT_W-WEIGHT_FRAC){1'b0}}, 1'b1, {(WEIGHT_FRAC-1){1'b0}}});
    localparam logic signed [RES_W-1:0] SAT_MAX =
        $signed({{(RES_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}});
    localparam logic signed [RES_W-1:0] SAT_MIN = ~SAT_MAX;
    localparam logic [WSUM_W-1:0] WEIGHT_ONE =
        {{(WSUM_W-WEIGHT_FRAC){1'b0}}, {WEIGHT_FRAC{1'b0}}} |
        ({{(WSUM_W-1){1'b0}}, 1'b1} << WEIGHT_FRAC);

    // ------------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] r_cp [NUM_POINTS];
    logic [COUNT_W-1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_POINTS; i++) begin
                r_cp[i] <= '0;
            end
            r_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_CP0, CFG_IDX_CP1, CFG_IDX_CP2, CFG_IDX_CP3: begin
                    r_cp[i_cfg_idx[1:0]] <= i_cfg_data;
                end
                CFG_IDX_COUNT: begin
                    r_count <= i_cfg_data[COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Each coordinate occupies COORD_WIDTH bits of its register; fields that
    // run past the top of the register read as zero.
    logic [PAD_W-1:0]              w_pad   [NUM_POINTS];
    logic signed [COORD_WIDTH-1:0] w_coord [NUM_POINTS][NUM_AXES];

    always_comb begin
        for (int i = 0; i < NUM_POINTS; i++) begin
            w_pad[i] = PAD_W'(r_cp[i]);
            for (int c = 0; c < NUM_AXES; c++) begin
                w_coord[i][c] = $signed(w_pad[i][c*COORD_WIDTH +: COORD_WIDTH]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Entry: range check and control pipeline.
    // ------------------------------------------------------------------------
    logic w_accept;
    logic n_err;

    assign busy     = ~i_rst_n;
    assign w_accept = start && !busy;
    // A zero count makes every index fail this check, so no division by zero
    // ever reaches the output.
    assign n_err    = EXT_W'(i_sample_index) >= EXT_W'(r_count);

    t_ctrl r_ctl [NUM_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                r_ctl[k] <= '0;
            end
        end else begin
            r_ctl[0] <= '{vld: w_accept, err: n_err};
            for (int k = 1; k < NUM_STAGES; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Restoring divider: u = floor(w * 2^16 / count). Since w < count the
    // partial remainder always fits in COUNT_W bits.
    // ------------------------------------------------------------------------
    logic [COUNT_W-1:0]   r_rem [DIV_STAGES+1];
    logic [FRAC_BITS-1:0] r_q   [DIV_STAGES+1];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= COUNT_W'(i_sample_index);
        r_q[0]   <= '0;
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic [COUNT_W-1:0]   n_rem;
        logic [FRAC_BITS-1:0] n_q;

        always_comb begin
            logic [COUNT_W:0] v_dbl;
            v_dbl = '0;
            n_rem = r_rem[k];
            n_q   = r_q[k];
            for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
                v_dbl = {n_rem, 1'b0};
                if (v_dbl >= {1'b0, r_count}) begin
                    n_rem = COUNT_W'(v_dbl - {1'b0, r_count});
                    n_q   = {n_q[FRAC_BITS-2:0], 1'b1};
                end else begin
                    n_rem = v_dbl[COUNT_W-1:0];
                    n_q   = {n_q[FRAC_BITS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= n_rem;
            r_q[k+1]   <= n_q;
        end
    end

    // ------------------------------------------------------------------------
    // M1: s = 1 - u, then s^2, u^2, 3s and 3u.
    // ------------------------------------------------------------------------
    logic [FRAC_BITS-1:0] w_t;
    logic [S_W-1:0]       n_s;
    logic [2*S_W-1:0]     n_s2_full;
    logic [T2_W-1:0]      n_t2;

    assign w_t       = r_q[DIV_STAGES];
    assign n_s       = ONE_Q - {1'b0, w_t};
    assign n_s2_full = (2*S_W)'(n_s) * (2*S_W)'(n_s);
    assign n_t2      = T2_W'(w_t) * T2_W'(w_t);

    logic [S_W-1:0]       r_s;
    logic [FRAC_BITS-1:0] r_t;
    logic [S2_W-1:0]      r_s2;
    logic [T2_W-1:0]      r_t2;
    logic [X3_W-1:0]      r_s3x;
    logic [X3_W-1:0]      r_t3x;

    always_ff @(posedge i_clk) begin
        r_s   <= n_s;
        r_t   <= w_t;
        r_s2  <= n_s2_full[S2_W-1:0];
        r_t2  <= n_t2;
        r_s3x <= X3_W'({n_s, 1'b0}) + X3_W'(n_s);
        r_t3x <= X3_W'({w_t, 1'b0}) + X3_W'(w_t);
    end

    // ------------------------------------------------------------------------
    // M2: Bernstein weights s^3, 3s^2u, 3su^2, u^3 in Q0.48. They always add
    // up to exactly one.
    // ------------------------------------------------------------------------
    logic [S2_W+S_W-1:0]       n_wt0_full;
    logic [S2_W+X3_W-1:0]      n_wt1_full;
    logic [T2_W+X3_W-1:0]      n_wt2_full;
    logic [T2_W+FRAC_BITS-1:0] n_wt3_full;

    assign n_wt0_full = (S2_W+S_W)'(r_s2) * (S2_W+S_W)'(r_s);
    assign n_wt1_full = (S2_W+X3_W)'(r_s2) * (S2_W+X3_W)'(r_t3x);
    assign n_wt2_full = (T2_W+X3_W)'(r_t2) * (T2_W+X3_W)'(r_s3x);
    assign n_wt3_full = (T2_W+FRAC_BITS)'(r_t2) * (T2_W+FRAC_BITS)'(r_t);

    logic [WEIGHT_W-1:0] r_wt [NUM_POINTS];

    always_ff @(posedge i_clk) begin
        r_wt[0] <= n_wt0_full[WEIGHT_W-1:0];
        r_wt[1] <= n_wt1_full[WEIGHT_W-1:0];
        r_wt[2] <= n_wt2_full[WEIGHT_W-1:0];
        r_wt[3] <= WEIGHT_W'(n_wt3_full);
    end

    // ------------------------------------------------------------------------
    // M3: each coordinate times the high and low slices of each weight, which
    // keeps every multiplier at COORD_WIDTH x 25 bits or narrower.
    // ------------------------------------------------------------------------
    logic signed [PH_W-1:0] r_ph [NUM_AXES][NUM_POINTS];
    logic signed [PL_W-1:0] r_pl [NUM_AXES][NUM_POINTS];

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NUM_AXES; c++) begin
            for (int i = 0; i < NUM_POINTS; i++) begin
                r_ph[c][i] <= PH_W'(w_coord[i][c]) *
                              $signed({1'b0, r_wt[i][WEIGHT_W-1:WT_LO_W]});
                r_pl[c][i] <= PL_W'(w_coord[i][c]) *
                              $signed({1'b0, r_wt[i][WT_LO_W-1:0]});
            end
        end
    end

    // ------------------------------------------------------------------------
    // M4: sum the four products of each slice.
    // ------------------------------------------------------------------------
    logic signed [HS_W-1:0] r_hsum [NUM_AXES];
    logic signed [LS_W-1:0] r_lsum [NUM_AXES];

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NUM_AXES; c++) begin
            r_hsum[c] <= HS_W'(r_ph[c][0]) + HS_W'(r_ph[c][1]) +
                         HS_W'(r_ph[c][2]) + HS_W'(r_ph[c][3]);
            r_lsum[c] <= LS_W'(r_pl[c][0]) + LS_W'(r_pl[c][1]) +
                         LS_W'(r_pl[c][2]) + LS_W'(r_pl[c][3]);
        end
    end

    // ------------------------------------------------------------------------
    // M5: recombine the slices, add one half, drop the 48 fraction bits
    // (floor, so exact halves round up), saturate, zero error items and register the result.
    // ------------------------------------------------------------------------
    logic signed [TOT_W-1:0]       n_tot [NUM_AXES];
    logic signed [RES_W-1:0]       n_res [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] n_pt  [NUM_AXES];

    always_comb begin
        for (int c = 0; c < NUM_AXES; c++) begin
            n_tot[c] = (TOT_W'(r_hsum[c]) <<< WT_LO_W) + TOT_W'(r_lsum[c]) +
                       ROUND_HALF;
            n_res[c] = n_tot[c][TOT_W-1:WEIGHT_FRAC];
            if (r_ctl[ST_M4].err) begin
                n_pt[c] = '0;
            end else if (n_res[c] > SAT_MAX) begin
                n_pt[c] = SAT_MAX[COORD_WIDTH-1:0];
            end else if (n_res[c] < SAT_MIN) begin
                n_pt[c] = SAT_MIN[COORD_WIDTH-1:0];
            end else begin
                n_pt[c] = n_res[c][COORD_WIDTH-1:0];
            end
        end
    end

    logic                          r_out_vld;
    logic                          r_out_err;
    logic signed [COORD_WIDTH-1:0] r_point [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_ctl[ST_M4].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_err <= r_ctl[ST_M4].err;
        for (int c = 0; c < NUM_AXES; c++) begin
            r_point[c] <= n_pt[c];
        end
    end

    assign o_valid       = r_out_vld;
    assign o_index_error = r_out_err;
    assign o_point_x     = r_point[0];
    assign o_point_y     = r_point[1];
    assign o_point_z     = r_point[2];

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------

    // Every accepted index is followed by its result strobe on o_valid.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY o_valid)
        else $error("result strobe missing after accepted index");

    // The Bernstein weights of a live item form a partition of unity.
    a_weight_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[ST_M2].vld |->
            (WSUM_W'(r_wt[0]) + WSUM_W'(r_wt[1]) + WSUM_W'(r_wt[2]) +
             WSUM_W'(r_wt[3])) == WEIGHT_ONE)
        else $error("Bernstein weights do not sum to one");

    // An out-of-range index leaves as the zero point.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_index_error |->
            o_point_x == '0 && o_point_y == '0 && o_point_z == '0)
        else $error("error result carries a nonzero point");

    // The multiply and sum stages only see items that left the divider.
    a_m1_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[ST_M1].vld |-> $past(r_ctl[DIV_STAGES].vld))
        else $error("valid bit appeared inside the pipeline");

endmodule
